FILE: hw/rtl/calendar_date_counter_defines.svh
// Assertion macros used by the calendar date counter RTL.
`ifndef CALENDAR_DATE_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_DEFINES_SVH

// Checked on every rising edge while the block is out of reset.
`define CDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/cdc_pkg.sv
// Types, codes and calendar helpers for the calendar date counter.
`default_nettype none
package cdc_pkg;

  localparam int OP_W    = 2;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 12;
  localparam int STAT_W  = 2;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STAT_W-1:0]  status_t;

  localparam op_t OP_LOAD = 2'd0;
  localparam op_t OP_ADD  = 2'd1;
  localparam op_t OP_BACK = 2'd2;
  localparam op_t OP_CMP  = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NO_DATE = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

  localparam year_t  YEAR_MIN      = 14'd1600;
  localparam year_t  YEAR_MAX      = 14'd9999;
  localparam count_t MAX_ADD_COUNT = 12'd4095;
  localparam month_t MONTHS        = 4'd12;
  localparam day_t   FEB_LEAP_LEN  = 5'd29;
  localparam day_t   DEC_LEN       = 5'd31;
  localparam month_t FEB           = 4'd2;

  // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam day_t MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Length of month m; zero for a month number outside 1 to 12.
  function automatic day_t days_in(month_t m, logic leap);
    day_t len;
    len = '0;
    if (m >= 4'd1 && m <= MONTHS) begin
      len = MONTH_LEN[4'(m - 4'd1)];
      if (m == FEB && leap) begin
        len = FEB_LEAP_LEN;
      end
    end
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cdc_in_if.sv
// Request channel of the calendar date counter.
`default_nettype none
interface cdc_in_if;
  import cdc_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  day_t   day_in;
  month_t month_in;
  year_t  year_in;
  count_t day_count;

  modport source (output valid, operation, day_in, month_in, year_in, day_count,
                  input ready);
  modport sink   (input valid, operation, day_in, month_in, year_in, day_count,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cdc_out_if.sv
// Result channel of the calendar date counter.
`default_nettype none
interface cdc_out_if;
  import cdc_pkg::*;

  logic    valid;
  logic    ready;
  day_t    day_out;
  month_t  month_out;
  year_t   year_out;
  logic    date_valid;
  logic    dates_equal;
  status_t status;

  modport source (output valid, day_out, month_out, year_out, date_valid, dates_equal,
                  status, input ready);
  modport sink   (input valid, day_out, month_out, year_out, date_valid, dates_equal,
                  status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/calendar_date_counter.sv
// Calendar date counter: holds one Gregorian date and applies one operation per request.
// Each request gives exactly one result, held on the result channel until it is taken; no new
// request is accepted from acceptance until the cycle after the result is taken. Load, step
// back and compare wait for the pipelined leap-year unit, then execute, then present. Add
// walks the date one month per cycle and waits for the leap-year unit again each time it
// crosses into a new year; day counts above 4095 are clamped to that largest count.
`default_nettype none
`include "calendar_date_counter_defines.svh"
module calendar_date_counter (
  input  wire logic clk,
  input  wire logic rst_n,
  cdc_in_if.sink    in_req,
  cdc_out_if.source out_rsp
);
  import cdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       wait_r, wait_nxt;
  op_t        op_r, op_nxt;
  day_t       di_r, di_nxt;
  month_t     mi_r, mi_nxt;
  day_t       d_w_r, d_w_nxt;
  month_t     m_w_r, m_w_nxt;
  year_t      y_w_r, y_w_nxt;
  count_t     left_r, left_nxt;
  day_t       cur_day_r, cur_day_nxt;
  month_t     cur_month_r, cur_month_nxt;
  year_t      cur_year_r, cur_year_nxt;
  status_t    out_status_r, out_status_nxt;
  logic       out_eq_r, out_eq_nxt;
  day_t       out_day_r;
  month_t     out_month_r;
  year_t      out_year_r;

  logic       leap;
  logic       have;
  logic       finish;
  month_t     dim_m;
  day_t       dim;
  logic [5:0] to_next;
  year_t      y_inc;

  cdc_leap u_leap (
    .clk  (clk),
    .year (y_w_r),
    .leap (leap)
  );

  assign have  = (cur_month_r != '0);
  assign y_inc = 14'(y_w_r + 14'd1);

  // One month-length lookup serves every operation.
  always_comb begin
    if (state_r == S_ADD) begin
      dim_m = m_w_r;
    end else if (op_r == OP_LOAD) begin
      dim_m = mi_r;
    end else begin
      dim_m = 4'(cur_month_r - 4'd1);
    end
    dim     = days_in(dim_m, leap);
    to_next = 6'(dim) - 6'(d_w_r) + 6'd1;
  end

  always_comb begin
    state_nxt      = state_r;
    wait_nxt       = wait_r;
    op_nxt         = op_r;
    di_nxt         = di_r;
    mi_nxt         = mi_r;
    d_w_nxt        = d_w_r;
    m_w_nxt        = m_w_r;
    y_w_nxt        = y_w_r;
    left_nxt       = left_r;
    cur_day_nxt    = cur_day_r;
    cur_month_nxt  = cur_month_r;
    cur_year_nxt   = cur_year_r;
    out_status_nxt = out_status_r;
    out_eq_nxt     = out_eq_r;
    finish         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt   = in_req.operation;
          di_nxt   = in_req.day_in;
          mi_nxt   = in_req.month_in;
          d_w_nxt  = cur_day_r;
          m_w_nxt  = cur_month_r;
          left_nxt = (in_req.day_count > MAX_ADD_COUNT) ? MAX_ADD_COUNT : in_req.day_count;
          if (in_req.operation == OP_LOAD || in_req.operation == OP_CMP) begin
            y_w_nxt = in_req.year_in;
          end else begin
            y_w_nxt = cur_year_r;
          end
          wait_nxt  = 1'b0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // Wait here until the leap unit's registered flag reflects y_w_r.
        wait_nxt = 1'b1;
        if (wait_r) begin
          state_nxt = (op_r == OP_ADD && have) ? S_ADD : S_EXEC;
        end
      end
      S_EXEC: begin
        finish         = 1'b1;
        out_status_nxt = ST_OK;
        out_eq_nxt     = 1'b0;
        unique case (op_r)
          OP_LOAD: begin
            if (y_w_r >= YEAR_MIN && y_w_r <= YEAR_MAX && di_r != '0 && di_r <= dim) begin
              cur_day_nxt   = di_r;
              cur_month_nxt = mi_r;
              cur_year_nxt  = y_w_r;
            end else begin
              cur_day_nxt    = '0;
              cur_month_nxt  = '0;
              cur_year_nxt   = '0;
              out_status_nxt = ST_NO_DATE;
            end
          end
          OP_ADD: begin
            // A valid date goes through S_ADD; only the zero date lands here.
            out_status_nxt = ST_NO_DATE;
          end
          OP_BACK: begin
            if (!have) begin
              out_status_nxt = ST_NO_DATE;
            end else if (cur_day_r == 5'd1 && cur_month_r == 4'd1 && cur_year_r <= YEAR_MIN) begin
              out_status_nxt = ST_RANGE;
            end else if (cur_day_r > 5'd1) begin
              cur_day_nxt = 5'(cur_day_r - 5'd1);
            end else if (cur_month_r == 4'd1) begin
              cur_day_nxt   = DEC_LEN;
              cur_month_nxt = MONTHS;
              cur_year_nxt  = 14'(cur_year_r - 14'd1);
            end else begin
              cur_month_nxt = dim_m;
              cur_day_nxt   = dim;
            end
          end
          OP_CMP: begin
            if (!have) begin
              out_status_nxt = ST_NO_DATE;
            end else begin
              out_eq_nxt = (di_r == cur_day_r) && (mi_r == cur_month_r) &&
                           (y_w_r == cur_year_r);
            end
          end
          default: begin
            out_status_nxt = ST_NO_DATE;
          end
        endcase
      end
      S_ADD: begin
        out_eq_nxt = 1'b0;
        if (left_r >= 12'(to_next)) begin
          left_nxt = 12'(left_r - 12'(to_next));
          d_w_nxt  = 5'd1;
          if (m_w_r == MONTHS) begin
            m_w_nxt = 4'd1;
            if (y_inc > YEAR_MAX) begin
              finish         = 1'b1;
              out_status_nxt = ST_RANGE;
            end else begin
              // New year: wait for its leap flag before the next month.
              y_w_nxt   = y_inc;
              wait_nxt  = 1'b0;
              state_nxt = S_WAIT;
            end
          end else begin
            m_w_nxt = 4'(m_w_r + 4'd1);
          end
        end else begin
          finish         = 1'b1;
          out_status_nxt = ST_OK;
          cur_day_nxt    = 5'(d_w_r + 5'(left_r));
          cur_month_nxt  = m_w_r;
          cur_year_nxt   = y_w_r;
        end
      end
      S_OUT: begin
        if (out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      cur_day_r   <= '0;
      cur_month_r <= '0;
      cur_year_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    di_r         <= di_nxt;
    mi_r         <= mi_nxt;
    d_w_r        <= d_w_nxt;
    m_w_r        <= m_w_nxt;
    y_w_r        <= y_w_nxt;
    left_r       <= left_nxt;
    out_status_r <= out_status_nxt;
    out_eq_r     <= out_eq_nxt;
    if (finish) begin
      out_day_r   <= cur_day_nxt;
      out_month_r <= cur_month_nxt;
      out_year_r  <= cur_year_nxt;
    end
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = (state_r == S_OUT);
  assign out_rsp.day_out     = out_day_r;
  assign out_rsp.month_out   = out_month_r;
  assign out_rsp.year_out    = out_year_r;
  assign out_rsp.date_valid  = (out_month_r != '0);
  assign out_rsp.dates_equal = out_eq_r;
  assign out_rsp.status      = out_status_r;

  `CDC_ASSERT(a_one_side, !(in_req.ready && out_rsp.valid), "request and result both open")
  `CDC_ASSERT(a_date_zero, (cur_month_r == '0) == (cur_day_r == '0), "partial zero date stored")
  `CDC_ASSERT(a_year_range, out_rsp.valid && out_rsp.date_valid |-> out_rsp.year_out >= YEAR_MIN && out_rsp.year_out <= YEAR_MAX, "result year out of range")
  `CDC_ASSERT(a_eq_ok, out_rsp.valid && out_rsp.dates_equal |-> out_rsp.status == ST_OK && out_rsp.date_valid, "equal flag with bad status")
  `CDC_ASSERT(a_fail_keeps, out_rsp.valid && $rose(out_rsp.valid) && out_rsp.status == ST_RANGE |-> $stable(cur_year_r), "range failure changed the date")

endmodule
`default_nettype wire

FILE: hw/rtl/cdc_leap.sv
// Two-stage leap-year unit: reciprocal multiply for the century, then the rule.
`default_nettype none
module cdc_leap (
  input  wire logic          clk,
  input  wire cdc_pkg::year_t year,
  output logic               leap
);
  import cdc_pkg::*;

  year_t       yr_s1_r;
  logic [26:0] prod_r;
  logic        leap_r;

  logic [7:0]  cent;
  year_t       rem;
  logic        leap_nxt;

  always_ff @(posedge clk) begin
    yr_s1_r <= year;
    prod_r  <= 27'(year) * 27'(RECIP_100);
    leap_r  <= leap_nxt;
  end

  always_comb begin
    cent = 8'(prod_r >> RECIP_SHIFT);
    rem  = 14'(yr_s1_r - (14'(cent) * 14'd100));
    // Divisible by 4 but not by 100, or divisible by 400.
    leap_nxt = ((yr_s1_r[1:0] == 2'd0) && (rem != '0)) ||
               ((rem == '0) && (cent[1:0] == 2'd0));
  end

  assign leap = leap_r;

endmodule
`default_nettype wire
